[src/assert_macros.svh]
// Assertion macros for the checker file of the wind speed aggregator.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define WSMGA_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define WSMGA_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wsmga_pkg.sv]
// Package for the wind speed mean and gust aggregator.
// Field widths, register indexes, reset values and fixed-point constants.
`timescale 1ns / 1ps

package wsmga_pkg;

  // Default parameter values
  localparam int ADC_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int MVPC_W     = 20;
  localparam int CFGS_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MVPC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATIO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = 2'd3;

  localparam logic [MVPC_W-1:0]        MVPC_RST   = 20'd52813;
  localparam logic signed [CFGS_W-1:0] RATIO_RST  = 16'sd6144;
  localparam logic signed [CFGS_W-1:0] FACTOR_RST = 16'sd256;
  localparam logic signed [CFGS_W-1:0] OFFSET_RST = 16'sd0;

  // Divider ratio as used in the product: positive unsigned Q3.12 only
  localparam int                       RATIO_EFF_W = 15;
  localparam logic [RATIO_EFF_W-1:0]   RATIO_ONE   = 15'd4096;

  // Fixed-point split and shifts
  localparam int LO_W      = 18;
  localparam int MV_SHIFT  = 28;
  localparam int SPD_FRAC  = 8;

  // Result and accumulator widths
  localparam int SPEED_W  = 20;
  localparam int MV_OUT_W = 16;
  localparam int SS_W     = 36;
  localparam int MS_W     = 32;
  localparam int DIV_W    = SS_W + 1;

  localparam logic [SPEED_W-1:0]  SPEED_MAX  = '1;
  localparam logic [MV_OUT_W-1:0] MV_OUT_MAX = '1;

endpackage

[src/wind_speed_mean_gust_aggregator.sv]
// Top level of the wind speed mean and gust aggregator: sequencer, state, config.
// Depends on wsmga_pkg, wsmga_mul and wsmga_div.
//
//   channel | ports                               | direction | payload
//   --------+-------------------------------------+-----------+---------------------------
//   in      | in_valid, in_stall                  | into      | in_mode, in_raw
//   out     | out_valid, out_stall                | out of    | mean speed, gust, mean mV
//   cfg     | cfg_we, cfg_idx, cfg_wdata          | into      | four setup registers
//
// A sample request occupies the block for four passes through the one shared multiplier,
// with mV, offset, speed and accumulate steps among and after them.
// A report with samples then waits in the bit-serial divider until both quotients are done;
// a report with no samples does not use the divider. A report also waits while an earlier result is
// still held at the output. Reset is synchronous and clears sums, count, gust and config.
// out_stall only holds the output register; a new request is taken meanwhile.
`timescale 1ns / 1ps

module wind_speed_mean_gust_aggregator #(
  parameter int ADC_BITS   = wsmga_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = wsmga_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [ADC_BITS-1:0]                 in_raw,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wsmga_pkg::SPEED_W-1:0]       out_mean_speed,
  output logic [wsmga_pkg::SPEED_W-1:0]       out_gust_speed,
  output logic [wsmga_pkg::MV_OUT_W-1:0]      out_mean_mv,
  input  logic                                cfg_we,
  input  logic [wsmga_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [wsmga_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SPEED_W = wsmga_pkg::SPEED_W;
  localparam int MVO_W   = wsmga_pkg::MV_OUT_W;
  localparam int SS_W    = wsmga_pkg::SS_W;
  localparam int MS_W    = wsmga_pkg::MS_W;
  localparam int DIV_W   = wsmga_pkg::DIV_W;
  localparam int LO_W    = wsmga_pkg::LO_W;
  localparam int RE_W    = wsmga_pkg::RATIO_EFF_W;
  localparam int CFGS_W  = wsmga_pkg::CFGS_W;
  localparam int MVPC_W  = wsmga_pkg::MVPC_W;
  localparam int SFRAC   = wsmga_pkg::SPD_FRAC;

  // raw * scale, its split and the divider-ratio partial products
  localparam int R1_W   = ADC_BITS + MVPC_W;
  localparam int HI_W   = R1_W - LO_W;
  localparam int LO_P_W = LO_W + RE_W;
  localparam int HI_P_W = HI_W + RE_W;
  localparam int TOT_W  = R1_W + RE_W + 1;
  localparam int MV_W   = TOT_W - wsmga_pkg::MV_SHIFT;
  localparam int D_W    = MV_W + 2;
  localparam int MA_W   = (D_W > LO_W + 1) ? D_W : LO_W + 1;
  localparam int MB_W   = MVPC_W + 1;
  localparam int P_W    = MA_W + MB_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_M1   = 10'b0000000010,
    S_M2   = 10'b0000000100,
    S_M3   = 10'b0000001000,
    S_MV   = 10'b0000010000,
    S_SUB  = 10'b0000100000,
    S_M4   = 10'b0001000000,
    S_SPD  = 10'b0010000000,
    S_ACC  = 10'b0100000000,
    S_DIV  = 10'b1000000000
  } state_t;

  // control and state
  state_t                    state_r, state_nxt;
  logic [SS_W-1:0]           ss_r, ss_nxt;
  logic [MS_W-1:0]           ms_r, ms_nxt;
  logic [COUNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [SPEED_W-1:0]        gust_r, gust_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // configuration
  logic [MVPC_W-1:0]         mvpc_r, mvpc_nxt;
  logic signed [CFGS_W-1:0]  ratio_r, ratio_nxt;
  logic signed [CFGS_W-1:0]  factor_r, factor_nxt;
  logic signed [CFGS_W-1:0]  offset_r, offset_nxt;

  // working payload
  logic                      mode_r, mode_nxt;
  logic [ADC_BITS-1:0]       raw_r, raw_nxt;
  logic [HI_W-1:0]           hi_r, hi_nxt;
  logic [LO_P_W-1:0]         lo_r, lo_nxt;
  logic [MV_W-1:0]           mv_r, mv_nxt;
  logic signed [D_W-1:0]     d_r, d_nxt;
  logic [SPEED_W-1:0]        speed_r, speed_nxt;
  logic [SPEED_W-1:0]        mean_spd_r, mean_spd_nxt;
  logic [SPEED_W-1:0]        gust_out_r, gust_out_nxt;
  logic [MVO_W-1:0]          mean_mv_r, mean_mv_nxt;

  // shared multiplier
  logic                      mul_en;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [P_W-1:0]     mul_p;

  // dividers
  logic                      div_start;
  logic                      spd_busy, mv_busy;
  logic [DIV_W-1:0]          spd_dvd, mv_dvd;
  logic [DIV_W-1:0]          spd_q, mv_q;

  // datapath helpers
  logic [RE_W-1:0]           ratio_eff;
  logic [TOT_W-1:0]          mv_total;
  logic [P_W-1:0]            spd_rnd;
  logic [P_W-1:0]            spd_shr;
  logic [SPEED_W-1:0]        spd_calc;
  logic [SS_W:0]             ss_add;
  logic [MS_W:0]             ms_add;
  logic [MVO_W-1:0]          mv_sat;
  logic                      out_free;

  wsmga_mul #(.AW(MA_W), .BW(MB_W)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  wsmga_div #(.DW(DIV_W), .VW(COUNT_BITS)) u_div_spd (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (spd_dvd),
    .divisor  (cnt_r),
    .busy     (spd_busy),
    .quo      (spd_q)
  );

  wsmga_div #(.DW(DIV_W), .VW(COUNT_BITS)) u_div_mv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mv_dvd),
    .divisor  (cnt_r),
    .busy     (mv_busy),
    .quo      (mv_q)
  );

  // non-positive divider ratio counts as 1.0
  assign ratio_eff = (!ratio_r[CFGS_W-1] && (ratio_r != '0)) ? ratio_r[RE_W-1:0]
                                                            : wsmga_pkg::RATIO_ONE;

  // millivolts: low and high partial products recombined, half-up rounding
  assign mv_total = TOT_W'(lo_r)
                  + (TOT_W'(mul_p[HI_P_W-1:0]) << LO_W)
                  + (TOT_W'(1) << (wsmga_pkg::MV_SHIFT - 1));

  // speed: clamp at zero, round Q8 away, saturate at the field top
  assign spd_rnd = P_W'(mul_p) + (P_W'(1) << (SFRAC - 1));
  assign spd_shr = spd_rnd >> SFRAC;
  always_comb begin
    if (mul_p[P_W-1] || (mul_p == '0)) begin
      spd_calc = '0;
    end else if (spd_shr > P_W'(wsmga_pkg::SPEED_MAX)) begin
      spd_calc = wsmga_pkg::SPEED_MAX;
    end else begin
      spd_calc = spd_shr[SPEED_W-1:0];
    end
  end

  // saturating running sums
  assign ss_add = {1'b0, ss_r} + (SS_W + 1)'(speed_r);
  assign ms_add = {1'b0, ms_r} + (MS_W + 1)'(mv_r);
  assign mv_sat = (mv_r > MV_W'(wsmga_pkg::MV_OUT_MAX)) ? wsmga_pkg::MV_OUT_MAX
                                                       : mv_r[MVO_W-1:0];

  // rounded means: count/2 added before dividing
  assign spd_dvd = DIV_W'(ss_r) + DIV_W'(cnt_r >> 1);
  assign mv_dvd  = DIV_W'(ms_r) + DIV_W'(cnt_r >> 1);

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    ss_nxt       = ss_r;
    ms_nxt       = ms_r;
    cnt_nxt      = cnt_r;
    gust_nxt     = gust_r;
    mode_nxt     = mode_r;
    raw_nxt      = raw_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    mv_nxt       = mv_r;
    d_nxt        = d_r;
    speed_nxt    = speed_r;
    mean_spd_nxt = mean_spd_r;
    gust_out_nxt = gust_out_r;
    mean_mv_nxt  = mean_mv_r;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          raw_nxt   = in_raw;
          state_nxt = S_M1;
        end
      end
      // raw counts times mV-per-count scale
      S_M1: begin
        mul_en    = 1'b1;
        mul_a     = MA_W'(raw_r);
        mul_b     = MB_W'(mvpc_r);
        state_nxt = S_M2;
      end
      // low half times divider ratio; keep high half
      S_M2: begin
        hi_nxt    = mul_p[R1_W-1:LO_W];
        mul_en    = 1'b1;
        mul_a     = MA_W'(mul_p[LO_W-1:0]);
        mul_b     = MB_W'(ratio_eff);
        state_nxt = S_M3;
      end
      // high half times divider ratio; keep low product
      S_M3: begin
        lo_nxt    = mul_p[LO_P_W-1:0];
        mul_en    = 1'b1;
        mul_a     = MA_W'(hi_r);
        mul_b     = MB_W'(ratio_eff);
        state_nxt = S_MV;
      end
      S_MV: begin
        mv_nxt    = mv_total[TOT_W-1:wsmga_pkg::MV_SHIFT];
        state_nxt = S_SUB;
      end
      S_SUB: begin
        d_nxt     = D_W'({1'b0, mv_r}) - D_W'(offset_r);
        state_nxt = S_M4;
      end
      // (mV - offset) times speed factor
      S_M4: begin
        mul_en    = 1'b1;
        mul_a     = MA_W'(d_r);
        mul_b     = MB_W'(factor_r);
        state_nxt = S_SPD;
      end
      S_SPD: begin
        speed_nxt = spd_calc;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!mode_r) begin
          // sample: sums and count freeze once the count is full
          if (cnt_r != '1) begin
            ss_nxt  = ss_add[SS_W] ? '1 : ss_add[SS_W-1:0];
            ms_nxt  = ms_add[MS_W] ? '1 : ms_add[MS_W-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end
          if (speed_r > gust_r) begin
            gust_nxt = speed_r;
          end
          state_nxt = S_IDLE;
        end else if (cnt_r == '0) begin
          // empty period: report this request's own reading
          if (out_free) begin
            mean_spd_nxt  = speed_r;
            gust_out_nxt  = speed_r;
            mean_mv_nxt   = mv_sat;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!spd_busy && !mv_busy && out_free) begin
          mean_spd_nxt  = (spd_q > DIV_W'(wsmga_pkg::SPEED_MAX)) ? wsmga_pkg::SPEED_MAX
                                                                 : spd_q[SPEED_W-1:0];
          mean_mv_nxt   = (mv_q > DIV_W'(wsmga_pkg::MV_OUT_MAX)) ? wsmga_pkg::MV_OUT_MAX
                                                                : mv_q[MVO_W-1:0];
          gust_out_nxt  = gust_r;
          out_valid_nxt = 1'b1;
          ss_nxt        = '0;
          ms_nxt        = '0;
          cnt_nxt       = '0;
          gust_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_comb begin
    mvpc_nxt   = mvpc_r;
    ratio_nxt  = ratio_r;
    factor_nxt = factor_r;
    offset_nxt = offset_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        wsmga_pkg::CFG_IDX_MVPC:   mvpc_nxt   = cfg_wdata[MVPC_W-1:0];
        wsmga_pkg::CFG_IDX_RATIO:  ratio_nxt  = cfg_wdata[CFGS_W-1:0];
        wsmga_pkg::CFG_IDX_FACTOR: factor_nxt = cfg_wdata[CFGS_W-1:0];
        wsmga_pkg::CFG_IDX_OFFSET: offset_nxt = cfg_wdata[CFGS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ss_r        <= '0;
      ms_r        <= '0;
      cnt_r       <= '0;
      gust_r      <= '0;
      out_valid_r <= 1'b0;
      mvpc_r      <= wsmga_pkg::MVPC_RST;
      ratio_r     <= wsmga_pkg::RATIO_RST;
      factor_r    <= wsmga_pkg::FACTOR_RST;
      offset_r    <= wsmga_pkg::OFFSET_RST;
    end else begin
      state_r     <= state_nxt;
      ss_r        <= ss_nxt;
      ms_r        <= ms_nxt;
      cnt_r       <= cnt_nxt;
      gust_r      <= gust_nxt;
      out_valid_r <= out_valid_nxt;
      mvpc_r      <= mvpc_nxt;
      ratio_r     <= ratio_nxt;
      factor_r    <= factor_nxt;
      offset_r    <= offset_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    raw_r      <= raw_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    mv_r       <= mv_nxt;
    d_r        <= d_nxt;
    speed_r    <= speed_nxt;
    mean_spd_r <= mean_spd_nxt;
    gust_out_r <= gust_out_nxt;
    mean_mv_r  <= mean_mv_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_mean_speed = mean_spd_r;
  assign out_gust_speed = gust_out_r;
  assign out_mean_mv    = mean_mv_r;

endmodule

[src/wsmga_mul.sv]
// Shared signed multiplier with registered product.
// Depends on nothing; sized by the top level.
`timescale 1ns / 1ps

module wsmga_mul #(
  parameter int AW = 26,
  parameter int BW = 21
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] prod
);

  logic signed [AW+BW-1:0] prod_r;
  logic signed [AW+BW-1:0] prod_nxt;

  // product is taken only on the cycles the sequencer asks for it
  always_comb begin
    prod_nxt = en ? a * b : prod_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[src/wsmga_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle while busy.
// Depends on nothing; sized by the top level.
`timescale 1ns / 1ps

module wsmga_div #(
  parameter int DW = 37,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quo
);

  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] div_r, div_nxt;

  logic [VW:0] sh;
  logic [VW:0] diff;
  logic        ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    sh   = {rem_r, quo_r[DW-1]};
    diff = sh - {1'b0, div_r};
    ge   = (sh >= {1'b0, div_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VW-1:0] : sh[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

[src/wsmga_chk.sv]
// Port-level checker for the wind speed aggregator, bound to the top level.
// Depends on wsmga_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsmga_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [wsmga_pkg::SPEED_W-1:0]      out_mean_speed,
  input logic [wsmga_pkg::SPEED_W-1:0]      out_gust_speed,
  input logic [wsmga_pkg::MV_OUT_W-1:0]     out_mean_mv
);

  // a held result keeps its payload
  `WSMGA_AST_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_mean_speed) && $stable(out_gust_speed) && $stable(out_mean_mv), "result changed while stalled")

  // a taken request keeps the block busy for at least the next cycle
  `WSMGA_AST_NXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken but block idle next cycle")

  // the mean of a period never exceeds its gust
  `WSMGA_AST_IMP(a_mean_le_gust, out_valid, out_mean_speed <= out_gust_speed, "mean speed above gust")

  // a new result only comes out of a request in progress
  `WSMGA_AST_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall), "result appeared with no request in progress")

endmodule

bind wind_speed_mean_gust_aggregator wsmga_chk u_wsmga_chk (.*);
